// File: rtl/core/ps2mpt_pkg.sv
// Shared types and constants for the PS/2 mouse packet tracker.
// Depends on nothing; imported by ps2_mouse_packet_tracker_top.

package ps2mpt_pkg;

    // Default width of one cursor coordinate and of the limit registers.
    localparam int COORD_WIDTH_DEFAULT = 11;

    // Reset values of the limit registers and of the cursor position.
    localparam int X_LIMIT_RESET = 1919;
    localparam int Y_LIMIT_RESET = 1079;
    localparam int POS_RESET     = 100;

    // Bit of a header byte that must be set for the byte to start a packet.
    localparam int HEADER_SYNC_BIT = 3;

    // Number of button bits carried in the low end of the header byte.
    localparam int BUTTON_BITS = 3;

    // Configuration register indexes.
    typedef enum logic {
        REG_X_LIMIT = 1'b0,
        REG_Y_LIMIT = 1'b1
    } cfg_reg_t;

    // Position of the next byte within a three-byte packet.
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DX     = 2'd1,
        PH_DY     = 2'd2
    } phase_t;

    // Control decoded from the phase for the byte at the processing stage.
    typedef struct packed {
        logic header_load;
        logic dx_load;
        logic result_load;
    } phase_ctrl_t;

endpackage

// File: rtl/core/ps2_mouse_packet_tracker_top.sv
// Top level of the PS/2 mouse packet tracker: input register, packet
// decode, cursor update with clamping, and result register.
// Depends on ps2mpt_pkg.
//
//  Channel   Direction  Handshake              Payload
//  ---------------------------------------------------------------------
//  in        to block   in_valid / in_stall    rx_byte
//  out       from block out_valid / out_stall  buttons, cursor_x, cursor_y
//  cfg       to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An accepted byte is held in the input register, and the decode and clamp
// logic loads the result register; one byte is taken every cycle while
// in_stall is low. A third byte's result passes the input register, then
// the result register. The add and clamp of one coordinate sets the path
// length. Reset puts the cursor at 100,100, the limits at their defaults,
// and waits for a header. A stall on the output holds the result register;
// a third byte in the input register then waits behind it; in_stall rises.

module ps2_mouse_packet_tracker_top
    import ps2mpt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             rx_byte,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [BUTTON_BITS-1:0] buttons,
    output logic [COORD_WIDTH-1:0] cursor_x,
    output logic [COORD_WIDTH-1:0] cursor_y,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data
);

    // Two extra bits hold the sign and the carry of a coordinate update.
    localparam int SUM_WIDTH = COORD_WIDTH + 2;

    logic [COORD_WIDTH-1:0] x_limit_reg;
    logic [COORD_WIDTH-1:0] y_limit_reg;

    logic                   s1_valid_reg;
    logic [7:0]             s1_byte_reg;
    logic                   s1_advance;
    logic                   in_accept;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    phase_ctrl_t            ctrl;

    logic [7:0]             header_reg;
    logic [7:0]             dx_reg;
    logic [COORD_WIDTH-1:0] pos_x_reg;
    logic [COORD_WIDTH-1:0] pos_y_reg;
    logic [COORD_WIDTH-1:0] pos_x_next;
    logic [COORD_WIDTH-1:0] pos_y_next;

    logic signed [SUM_WIDTH-1:0] sum_x;
    logic signed [SUM_WIDTH-1:0] sum_y;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [BUTTON_BITS-1:0] buttons_reg;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= COORD_WIDTH'(X_LIMIT_RESET);
            y_limit_reg <= COORD_WIDTH'(Y_LIMIT_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_X_LIMIT: x_limit_reg <= cfg_data;
                REG_Y_LIMIT: y_limit_reg <= cfg_data;
                default:     x_limit_reg <= x_limit_reg;
            endcase
        end
    end

    // The input register moves on unless a result must wait for the output.
    assign s1_advance = s1_valid_reg && (!ctrl.result_load || !out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    // Next packet phase for the byte in the input register.
    always_comb
    begin
        phase_next = phase_reg;
        if (s1_advance)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (s1_byte_reg[HEADER_SYNC_BIT])
                    begin
                        phase_next = PH_DX;
                    end
                end
                PH_DX:   phase_next = PH_DY;
                default: phase_next = PH_HEADER;
            endcase
        end
    end

    // What the current phase does with the byte in the input register.
    always_comb
    begin
        ctrl = '0;
        case (phase_reg)
            PH_HEADER: ctrl.header_load = s1_byte_reg[HEADER_SYNC_BIT];
            PH_DX:     ctrl.dx_load     = 1'b1;
            default:   ctrl.result_load = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Header and X delta are kept until the third byte arrives.
    always_ff @(posedge clk)
    begin
        if (s1_advance && ctrl.header_load)
        begin
            header_reg <= s1_byte_reg;
        end
        if (s1_advance && ctrl.dx_load)
        begin
            dx_reg <= s1_byte_reg;
        end
    end

    // X adds its delta, Y subtracts the third byte; both clamp to 0..limit.
    always_comb
    begin
        sum_x = $signed({2'b00, pos_x_reg}) + SUM_WIDTH'($signed(dx_reg));
        sum_y = $signed({2'b00, pos_y_reg}) - SUM_WIDTH'($signed(s1_byte_reg));

        if (sum_x[SUM_WIDTH-1])
        begin
            pos_x_next = '0;
        end
        else if (sum_x[SUM_WIDTH-2:0] > {1'b0, x_limit_reg})
        begin
            pos_x_next = x_limit_reg;
        end
        else
        begin
            pos_x_next = sum_x[COORD_WIDTH-1:0];
        end

        if (sum_y[SUM_WIDTH-1])
        begin
            pos_y_next = '0;
        end
        else if (sum_y[SUM_WIDTH-2:0] > {1'b0, y_limit_reg})
        begin
            pos_y_next = y_limit_reg;
        end
        else
        begin
            pos_y_next = sum_y[COORD_WIDTH-1:0];
        end
    end

    // The cursor position doubles as the result register's coordinates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= COORD_WIDTH'(POS_RESET);
            pos_y_reg <= COORD_WIDTH'(POS_RESET);
        end
        else if (s1_advance && ctrl.result_load)
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && ctrl.result_load)
        begin
            buttons_reg <= header_reg[BUTTON_BITS-1:0];
        end
    end

    // A result stays valid until taken; a new one may replace it on the take.
    assign out_valid_next = (s1_advance && ctrl.result_load) || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign buttons   = buttons_reg;
    assign cursor_x  = pos_x_reg;
    assign cursor_y  = pos_y_reg;

    // A stall toward the input only comes from a waiting result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a waiting result");

    // A held item in the input register is not lost.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> s1_valid_reg)
        else $error("held item dropped from input register");

    // A byte without the sync bit in the header slot keeps the phase.
    a_resync: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && phase_reg == PH_HEADER && !s1_byte_reg[HEADER_SYNC_BIT])
        |=> (phase_reg == PH_HEADER))
        else $error("phase left header slot on a byte without sync bit");

    // A new result appears only after a third byte moved on.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg && out_stall))
        |-> $past(s1_advance && phase_reg == PH_DY))
        else $error("result produced without a completed packet");

endmodule
